// ===== rtl/core/c_subset_tokenizer_top_defines.svh =====
// Assertion macros for the tokenizer checker.
`ifndef C_SUBSET_TOKENIZER_TOP_DEFINES_SVH
`define C_SUBSET_TOKENIZER_TOP_DEFINES_SVH
`define CST_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CST_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== rtl/core/cst_pkg.sv =====
// Package with types, codes and helper functions of the tokenizer.
package cst_pkg;
  localparam int unsigned PosWidth = 16;
  localparam int unsigned LenWidth = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE,
    M_STRING, M_STRING_ESC, M_OPERATOR, M_LINE_COMMENT, M_BLOCK, M_BLOCK_STAR
  } mode_e;

  typedef enum logic [5:0] {
    KEof, KIdent, KInteger, KCharacter, KString,
    KKwInt, KKwChar, KKwVoid, KKwIf, KKwElse, KKwWhile, KKwFor, KKwReturn,
    KPlus, KMinus, KStar, KSlash, KPercent, KEq, KNe, KLt, KGt, KLe, KGe, KAssign,
    KInc, KDec, KLogAnd, KLogOr, KNot, KAnd, KOr, KXor, KTilde, KShl, KShr,
    KSemi, KColon, KComma, KDot, KLParen, KRParen, KLBrace, KRBrace, KLBrack, KRBrack,
    KHash, KError
  } kind_e;

  localparam logic [2:0] ErrNone = 3'd0;
  localparam logic [2:0] ErrEscape = 3'd1;
  localparam logic [2:0] ErrOpenChar = 3'd2;
  localparam logic [2:0] ErrOpenString = 3'd3;
  localparam logic [2:0] ErrUnexpected = 3'd4;

  typedef struct packed {
    logic [7:0] next_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [5:0]          token_kind;
    logic [PosWidth-1:0] line_no;
    logic [PosWidth-1:0] start_column;
    logic [LenWidth-1:0] text_length;
    logic [7:0]          literal_char;
    logic [2:0]          error_code;
    logic                last_of_run;
  } out_t;

  // Entry between the front and back: up to two tokens from one byte.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       tok0;
    out_t       tok1;
  } pair_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = KPlus;   "-": k = KMinus;   "*": k = KStar;   "/": k = KSlash;
      "%": k = KPercent; "<": k = KLt;     ">": k = KGt;     "=": k = KAssign;
      "!": k = KNot;    "&": k = KAnd;     "|": k = KOr;     "^": k = KXor;
      "~": k = KTilde;  ";": k = KSemi;    ":": k = KColon;  ",": k = KComma;
      ".": k = KDot;    "(": k = KLParen;  ")": k = KRParen; "{": k = KLBrace;
      "}": k = KRBrace; "[": k = KLBrack;  "]": k = KRBrack; "#": k = KHash;
      default: k = KEof;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = KEof;
    if (p == "+" && c == "+") k = KInc;
    if (p == "-" && c == "-") k = KDec;
    if (p == "=" && c == "=") k = KEq;
    if (p == "!" && c == "=") k = KNe;
    if (p == "<" && c == "=") k = KLe;
    if (p == "<" && c == "<") k = KShl;
    if (p == ">" && c == "=") k = KGe;
    if (p == ">" && c == ">") k = KShr;
    if (p == "&" && c == "&") k = KLogAnd;
    if (p == "|" && c == "|") k = KLogOr;
    return k;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [LenWidth-1:0] len,
                                            input logic [47:0] pre);
    logic [5:0] k;
    k = KIdent;
    if (len == LenWidth'(3) && pre == 48'h696E74) k = KKwInt;
    if (len == LenWidth'(4) && pre == 48'h63686172) k = KKwChar;
    if (len == LenWidth'(4) && pre == 48'h766F6964) k = KKwVoid;
    if (len == LenWidth'(2) && pre == 48'h6966) k = KKwIf;
    if (len == LenWidth'(4) && pre == 48'h656C7365) k = KKwElse;
    if (len == LenWidth'(5) && pre == 48'h7768696C65) k = KKwWhile;
    if (len == LenWidth'(3) && pre == 48'h666F72) k = KKwFor;
    if (len == LenWidth'(6) && pre == 48'h72657475726E) k = KKwReturn;
    return k;
  endfunction
endpackage

// ===== rtl/core/cst_front.sv =====
// Front end: scans each byte and forms up to two tokens per transaction.
module cst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cst_pkg::in_t     in_i,
  output logic             full_o,
  output logic             q_push_o,
  output cst_pkg::pair_t   q_data_o,
  input  logic             q_full_i
);
  localparam logic [cst_pkg::PosWidth-1:0] PosMax = '1;
  localparam logic [cst_pkg::LenWidth-1:0] LenMax = '1;

  cst_pkg::mode_e mode_q, mode_d;
  logic [cst_pkg::PosWidth-1:0] line_q, line_d, col_q, col_d;
  logic [cst_pkg::PosWidth-1:0] tline_q, tline_d, tcol_q, tcol_d;
  logic [cst_pkg::LenWidth-1:0] len_q, len_d;
  logic [47:0] pre_q, pre_d;
  logic [7:0] pend_q, pend_d, dec_q, dec_d;
  logic fin_q, fin_d;
  logic [7:0] c;
  logic fire, restart;
  cst_pkg::pair_t pr;

  assign full_o = q_full_i;
  assign fire = push_i && !q_full_i;
  assign c = in_i.next_byte;

  always_comb begin
    logic [5:0] k;
    logic [1:0] n;
    cst_pkg::out_t t;
    mode_d = mode_q; line_d = line_q; col_d = col_q; tline_d = tline_q;
    tcol_d = tcol_q; len_d = len_q; pre_d = pre_q; pend_d = pend_q;
    dec_d = dec_q; fin_d = fin_q; restart = 1'b0; pr = '0; n = 2'd0; k = '0;
    t = '0;
    // Emit helper done inline: fill slot n.
    if (!fin_q) begin
      if (in_i.end_of_input || c == 8'd0) begin
        t = '0; t.line_no = tline_q; t.start_column = tcol_q;
        unique case (mode_q)
          cst_pkg::M_IDENT: begin
            t.token_kind = cst_pkg::ident_kind(len_q, pre_q); t.text_length = len_q; n = 2'd1;
          end
          cst_pkg::M_NUMBER: begin
            t.token_kind = cst_pkg::KInteger; t.text_length = len_q; n = 2'd1;
          end
          cst_pkg::M_CHAR_OPEN, cst_pkg::M_CHAR_CLOSE: begin
            t.token_kind = cst_pkg::KError; t.error_code = cst_pkg::ErrOpenChar; n = 2'd1;
          end
          cst_pkg::M_CHAR_ESC: begin
            t.token_kind = cst_pkg::KError; t.error_code = cst_pkg::ErrEscape; n = 2'd1;
          end
          cst_pkg::M_STRING, cst_pkg::M_STRING_ESC: begin
            t.token_kind = cst_pkg::KError; t.error_code = cst_pkg::ErrOpenString; n = 2'd1;
          end
          cst_pkg::M_OPERATOR: begin
            t.token_kind = cst_pkg::single_kind(pend_q);
            t.text_length = cst_pkg::LenWidth'(1); n = 2'd1;
          end
          default: n = 2'd0;
        endcase
        pr.tok0 = t;
        t = '0; t.token_kind = cst_pkg::KEof; t.line_no = line_q; t.start_column = col_q;
        if (n == 2'd1) pr.tok1 = t;
        else pr.tok0 = t;
        n = n + 2'd1;
        mode_d = cst_pkg::M_IDLE; fin_d = 1'b1;
      end else begin
        t = '0; t.line_no = tline_q; t.start_column = tcol_q;
        unique case (mode_q)
          cst_pkg::M_IDENT: begin
            if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)) begin
              pre_d = (len_q < cst_pkg::LenWidth'(6)) ? {pre_q[39:0], c} : '1;
              if (len_q != LenMax) len_d = len_q + 1'b1;
            end else begin
              t.token_kind = cst_pkg::ident_kind(len_q, pre_q); t.text_length = len_q;
              n = 2'd1; restart = 1'b1;
            end
          end
          cst_pkg::M_NUMBER: begin
            if (cst_pkg::is_digit(c)) begin
              if (len_q != LenMax) len_d = len_q + 1'b1;
            end else begin
              t.token_kind = cst_pkg::KInteger; t.text_length = len_q;
              n = 2'd1; restart = 1'b1;
            end
          end
          cst_pkg::M_CHAR_OPEN: begin
            if (c == "\\") mode_d = cst_pkg::M_CHAR_ESC;
            else begin dec_d = c; mode_d = cst_pkg::M_CHAR_CLOSE; end
          end
          cst_pkg::M_CHAR_ESC: begin
            mode_d = cst_pkg::M_CHAR_CLOSE;
            case (c)
              "n": dec_d = 8'h0a;
              "t": dec_d = 8'h09;
              "r": dec_d = 8'h0d;
              "0": dec_d = 8'h00;
              "\\", "'", "\"": dec_d = c;
              default: begin
                mode_d = mode_q;
                t.token_kind = cst_pkg::KError; t.error_code = cst_pkg::ErrEscape;
                n = 2'd1; restart = 1'b1;
              end
            endcase
          end
          cst_pkg::M_CHAR_CLOSE: begin
            t.token_kind = (c == "'") ? cst_pkg::KCharacter : cst_pkg::KError;
            if (c == "'") begin
              t.text_length = cst_pkg::LenWidth'(1); t.literal_char = dec_q;
              mode_d = cst_pkg::M_IDLE;
            end else begin
              t.error_code = cst_pkg::ErrOpenChar; restart = 1'b1;
            end
            n = 2'd1;
          end
          cst_pkg::M_STRING: begin
            if (c == "\"") begin
              t.token_kind = cst_pkg::KString; t.text_length = len_q; n = 2'd1;
              mode_d = cst_pkg::M_IDLE;
            end else begin
              if (len_q != LenMax) len_d = len_q + 1'b1;
              if (c == "\\") mode_d = cst_pkg::M_STRING_ESC;
            end
          end
          cst_pkg::M_STRING_ESC: begin
            if (len_q != LenMax) len_d = len_q + 1'b1;
            mode_d = cst_pkg::M_STRING;
          end
          cst_pkg::M_OPERATOR: begin
            k = cst_pkg::pair_kind(pend_q, c);
            if (k != cst_pkg::KEof) begin
              t.token_kind = k; t.text_length = cst_pkg::LenWidth'(2); n = 2'd1;
              mode_d = cst_pkg::M_IDLE;
            end else if (pend_q == "/" && (c == "/" || c == "*")) begin
              mode_d = (c == "/") ? cst_pkg::M_LINE_COMMENT : cst_pkg::M_BLOCK;
            end else begin
              t.token_kind = cst_pkg::single_kind(pend_q);
              t.text_length = cst_pkg::LenWidth'(1); n = 2'd1; restart = 1'b1;
            end
          end
          cst_pkg::M_LINE_COMMENT: if (c == 8'h0a) mode_d = cst_pkg::M_IDLE;
          cst_pkg::M_BLOCK: if (c == "*") mode_d = cst_pkg::M_BLOCK_STAR;
          cst_pkg::M_BLOCK_STAR: begin
            if (c == "/") mode_d = cst_pkg::M_IDLE;
            else if (c != "*") mode_d = cst_pkg::M_BLOCK;
          end
          default: restart = 1'b1;
        endcase
        pr.tok0 = t;
        if (restart) begin
          tline_d = line_q; tcol_d = col_q; mode_d = cst_pkg::M_IDLE;
          t = '0; t.line_no = line_q; t.start_column = col_q;
          if (cst_pkg::is_space(c)) begin
          end else if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)) begin
            mode_d = cst_pkg::is_digit(c) ? cst_pkg::M_NUMBER : cst_pkg::M_IDENT;
            len_d = cst_pkg::LenWidth'(1); pre_d = {40'd0, c};
          end else if (c == "'") begin
            mode_d = cst_pkg::M_CHAR_OPEN;
          end else if (c == "\"") begin
            mode_d = cst_pkg::M_STRING; len_d = '0;
          end else if (c == "+" || c == "-" || c == "=" || c == "!" || c == "<" ||
                       c == ">" || c == "&" || c == "|" || c == "/") begin
            mode_d = cst_pkg::M_OPERATOR; pend_d = c;
          end else begin
            k = cst_pkg::single_kind(c);
            if (k != cst_pkg::KEof) begin
              t.token_kind = k; t.text_length = cst_pkg::LenWidth'(1);
            end else begin
              t.token_kind = cst_pkg::KError; t.error_code = cst_pkg::ErrUnexpected;
            end
            if (n == 2'd0) pr.tok0 = t;
            else pr.tok1 = t;
            n = n + 2'd1;
          end
        end
        // Every consumed byte advances the position.
        if (c == 8'h0a) begin
          if (line_q != PosMax) line_d = line_q + 1'b1;
          col_d = cst_pkg::PosWidth'(1);
        end else if (col_q != PosMax) begin
          col_d = col_q + 1'b1;
        end
      end
    end
    if (n == 2'd1) pr.tok0.last_of_run = 1'b1;
    if (n == 2'd2) pr.tok1.last_of_run = 1'b1;
    pr.cnt = n;
  end

  assign q_push_o = fire && (pr.cnt != 2'd0);
  assign q_data_o = pr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cst_pkg::M_IDLE;
      line_q <= cst_pkg::PosWidth'(1); col_q <= cst_pkg::PosWidth'(1);
      tline_q <= cst_pkg::PosWidth'(1); tcol_q <= cst_pkg::PosWidth'(1);
      len_q <= '0; pre_q <= '0; pend_q <= '0; dec_q <= '0; fin_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d; line_q <= line_d; col_q <= col_d;
      tline_q <= tline_d; tcol_q <= tcol_d; len_q <= len_d; pre_q <= pre_d;
      pend_q <= pend_d; dec_q <= dec_d; fin_q <= fin_d;
    end
  end
endmodule

// ===== rtl/core/cst_back.sv =====
// Back end: token queue that hands out the tokens of each entry one by one.
module cst_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_push_i,
  input  cst_pkg::pair_t q_data_i,
  output logic           q_full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output cst_pkg::out_t  data_o
);
  cst_pkg::pair_t mem_q [cst_pkg::QDepth];
  logic [cst_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [cst_pkg::QPtrW:0] cnt_q;
  logic sub_q;
  logic take, last;

  assign empty_o = (cnt_q == '0);
  assign q_full_o = (cnt_q == (cst_pkg::QPtrW+1)'(cst_pkg::QDepth));
  assign data_o = sub_q ? mem_q[rd_q].tok1 : mem_q[rd_q].tok0;
  assign take = pop_i && !empty_o;
  assign last = sub_q || (mem_q[rd_q].cnt == 2'd1);

  always_ff @(posedge clk_i) begin
    if (q_push_i) mem_q[wr_q] <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= 1'b0;
    end else begin
      if (q_push_i) wr_q <= wr_q + 1'b1;
      if (take) begin
        sub_q <= !last;
        if (last) rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (cst_pkg::QPtrW+1)'(q_push_i) - (cst_pkg::QPtrW+1)'(take && last);
    end
  end
endmodule

// ===== rtl/core/c_subset_tokenizer_top.sv =====
// Top level of the C-subset tokenizer.
// Channel | Direction | Handshake   | Payload
// input   | in        | push / full | cst_pkg::in_t
// result  | out       | empty / pop | cst_pkg::out_t
// One byte is taken per cycle while full is low; the scanner state is registered as the byte is taken.
// Tokens that a byte finishes are registered in the queue before they show on the result ports.
// A four-entry queue, each entry up to two tokens, sits between scanner and output.
// full rises only when it fills; reset clears all but its memory, no clearing pass.
module c_subset_tokenizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  cst_pkg::in_t  data_i,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output cst_pkg::out_t data_o
);
  logic q_push, q_full;
  cst_pkg::pair_t q_data;

  cst_front u_front (
    .clk_i, .rst_ni, .push_i(push), .in_i(data_i), .full_o(full),
    .q_push_o(q_push), .q_data_o(q_data), .q_full_i(q_full)
  );

  cst_back u_back (
    .clk_i, .rst_ni, .q_push_i(q_push), .q_data_i(q_data), .q_full_o(q_full),
    .empty_o(empty), .pop_i(pop), .data_o(data_o)
  );
endmodule

// ===== rtl/core/cst_checker.sv =====
// Port checker for the tokenizer top level.
`include "c_subset_tokenizer_top_defines.svh"
module cst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input cst_pkg::out_t data_o
);
  `CST_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> !empty && $stable(data_o))
  `CST_ASSERT(a_err, clk_i, rst_ni, (!empty && data_o.token_kind != cst_pkg::KError) |-> data_o.error_code == cst_pkg::ErrNone)
  `CST_ASSERT(a_eof, clk_i, rst_ni, (!empty && data_o.token_kind == cst_pkg::KEof) |-> data_o.last_of_run)
  `CST_ASSERT_NR(a_rst, clk_i, !rst_ni |=> empty && !full)
endmodule

bind c_subset_tokenizer_top cst_checker u_cst_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .data_o
);

// ===== verif/tb_c_subset_tokenizer_top.sv =====
// Self-checking testbench for the C-subset tokenizer: directed rows, then random source.
`timescale 1ns / 1ps

module tb_c_subset_tokenizer_top;
  typedef struct {
    logic [7:0]     b;
    logic           e;
    bit             chk;
    cst_pkg::kind_e k;
    logic [2:0]     er;
  } row_t;

  localparam logic [47:0] KW_TEXT [8] = '{48'h696E74, 48'h63686172, 48'h766F6964,
    48'h6966, 48'h656C7365, 48'h7768696C65, 48'h666F72, 48'h72657475726E};
  localparam int KW_LEN [8] = '{3, 4, 4, 2, 4, 5, 3, 6};
  localparam logic [15:0] SAT = 16'hFFFF;

  logic clk_i, rst_ni, push, full, empty, pop, quiet;
  cst_pkg::in_t  data_i;
  cst_pkg::out_t data_o, want;
  int   errors, n_sent;

  cst_pkg::mode_e sc_mode;
  logic [15:0] ln, col, tok_ln, tok_col, len_cnt;
  logic [47:0] kw_pre;
  logic [7:0]  pend_op, dec_ch;
  bit          eof_seen;
  cst_pkg::out_t step_toks[$];
  cst_pkg::out_t token_q[$];

  string      kw_names [8] = '{"int", "char", "void", "if", "else", "while", "for", "return"};
  string      ops = "+-*/%<>=!&|^~;:,.()[]{}#";
  string      cmt = "*/a \n*";
  logic [7:0] esc_set [7] = '{"n", "t", "r", "0", "\\", "'", "\""};
  logic [7:0] ws_set [6] = '{8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0b, 8'h0c};

  row_t dir_rows [] = '{
    '{"@", 0, 1, cst_pkg::KError, cst_pkg::ErrUnexpected},
    '{8'hFF, 0, 1, cst_pkg::KError, cst_pkg::ErrUnexpected},
    '{"'", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"\\", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"q", 0, 1, cst_pkg::KError, cst_pkg::ErrEscape},
    '{" ", 0, 1, cst_pkg::KIdent, cst_pkg::ErrNone},
    '{"'", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"a", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"b", 0, 1, cst_pkg::KError, cst_pkg::ErrOpenChar},
    '{";", 0, 1, cst_pkg::KIdent, cst_pkg::ErrNone},
    '{"'", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"'", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"'", 0, 1, cst_pkg::KCharacter, cst_pkg::ErrNone},
    '{"\"", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"\\", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"\"", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"\"", 0, 1, cst_pkg::KString, cst_pkg::ErrNone},
    '{"i", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"f", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"(", 0, 1, cst_pkg::KKwIf, cst_pkg::ErrNone},
    '{"<", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"<", 0, 1, cst_pkg::KShl, cst_pkg::ErrNone},
    '{"/", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"*", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"/", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"*", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{"/", 0, 0, cst_pkg::KEof, cst_pkg::ErrNone},
    '{8'h0a, 0, 0, cst_pkg::KEof, cst_pkg::ErrNone}
  };

  c_subset_tokenizer_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .data_i(data_i), .full(full),
    .empty(empty), .pop(pop), .data_o(data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic cst_pkg::kind_e op1(logic [7:0] c);
    case (c)
      "+": return cst_pkg::KPlus;    "-": return cst_pkg::KMinus;
      "*": return cst_pkg::KStar;    "/": return cst_pkg::KSlash;
      "%": return cst_pkg::KPercent; "<": return cst_pkg::KLt;
      ">": return cst_pkg::KGt;      "=": return cst_pkg::KAssign;
      "!": return cst_pkg::KNot;     "&": return cst_pkg::KAnd;
      "|": return cst_pkg::KOr;      "^": return cst_pkg::KXor;
      "~": return cst_pkg::KTilde;   ";": return cst_pkg::KSemi;
      ":": return cst_pkg::KColon;   ",": return cst_pkg::KComma;
      ".": return cst_pkg::KDot;     "(": return cst_pkg::KLParen;
      ")": return cst_pkg::KRParen;  "{": return cst_pkg::KLBrace;
      "}": return cst_pkg::KRBrace;  "[": return cst_pkg::KLBrack;
      "]": return cst_pkg::KRBrack;  "#": return cst_pkg::KHash;
      default: return cst_pkg::KEof;
    endcase
  endfunction

  function automatic cst_pkg::kind_e op2(logic [7:0] p, logic [7:0] c);
    if (p == "+" && c == "+") return cst_pkg::KInc;
    if (p == "-" && c == "-") return cst_pkg::KDec;
    if (p == "=" && c == "=") return cst_pkg::KEq;
    if (p == "!" && c == "=") return cst_pkg::KNe;
    if (p == "<" && c == "=") return cst_pkg::KLe;
    if (p == "<" && c == "<") return cst_pkg::KShl;
    if (p == ">" && c == "=") return cst_pkg::KGe;
    if (p == ">" && c == ">") return cst_pkg::KShr;
    if (p == "&" && c == "&") return cst_pkg::KLogAnd;
    if (p == "|" && c == "|") return cst_pkg::KLogOr;
    return cst_pkg::KEof;
  endfunction

  function automatic void put_tok(cst_pkg::kind_e k, logic [15:0] l, logic [15:0] c,
                                  logic [15:0] len, logic [7:0] lit, logic [2:0] er);
    cst_pkg::out_t t;
    if (step_toks.size() >= 2) return;
    t.token_kind = k;
    t.line_no = l;
    t.start_column = c;
    t.text_length = len;
    t.literal_char = lit;
    t.error_code = er;
    t.last_of_run = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void put_cur(cst_pkg::kind_e k, logic [15:0] len, logic [7:0] lit,
                                  logic [2:0] er);
    put_tok(k, tok_ln, tok_col, len, lit, er);
  endfunction

  function automatic void step_pos(logic [7:0] c);
    if (c == 8'h0a) begin
      if (ln != SAT) ln++;
      col = 16'd1;
    end else if (col != SAT) begin
      col++;
    end
  endfunction

  function automatic void grow_len();
    if (len_cnt != SAT) len_cnt++;
  endfunction

  function automatic void put_ident();
    cst_pkg::kind_e k;
    k = cst_pkg::KIdent;
    for (int i = 0; i < 8; i++)
      if (len_cnt == KW_LEN[i] && kw_pre == KW_TEXT[i])
        k = cst_pkg::kind_e'(int'(cst_pkg::KKwInt) + i);
    put_cur(k, len_cnt, 8'd0, cst_pkg::ErrNone);
  endfunction

  function automatic void begin_tok(logic [7:0] c);
    cst_pkg::kind_e k;
    tok_ln = ln;
    tok_col = col;
    sc_mode = cst_pkg::M_IDLE;
    if (is_blank(c)) begin
      step_pos(c);
    end else if (is_letter(c) || is_num(c)) begin
      sc_mode = is_num(c) ? cst_pkg::M_NUMBER : cst_pkg::M_IDENT;
      len_cnt = 16'd1;
      kw_pre = {40'd0, c};
      step_pos(c);
    end else if (c == "'") begin
      sc_mode = cst_pkg::M_CHAR_OPEN;
      step_pos(c);
    end else if (c == "\"") begin
      sc_mode = cst_pkg::M_STRING;
      len_cnt = 16'd0;
      step_pos(c);
    end else if (c inside {"+", "-", "=", "!", "<", ">", "&", "|", "/"}) begin
      sc_mode = cst_pkg::M_OPERATOR;
      pend_op = c;
      step_pos(c);
    end else begin
      k = op1(c);
      step_pos(c);
      if (k != cst_pkg::KEof) put_cur(k, 16'd1, 8'd0, cst_pkg::ErrNone);
      else put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrUnexpected);
    end
  endfunction

  function automatic void close_input();
    case (sc_mode)
      cst_pkg::M_IDENT: put_ident();
      cst_pkg::M_NUMBER: put_cur(cst_pkg::KInteger, len_cnt, 8'd0, cst_pkg::ErrNone);
      cst_pkg::M_CHAR_OPEN, cst_pkg::M_CHAR_CLOSE:
        put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrOpenChar);
      cst_pkg::M_CHAR_ESC: put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrEscape);
      cst_pkg::M_STRING, cst_pkg::M_STRING_ESC:
        put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrOpenString);
      cst_pkg::M_OPERATOR: put_cur(op1(pend_op), 16'd1, 8'd0, cst_pkg::ErrNone);
      default: ;
    endcase
    put_tok(cst_pkg::KEof, ln, col, 16'd0, 8'd0, cst_pkg::ErrNone);
    sc_mode = cst_pkg::M_IDLE;
    eof_seen = 1'b1;
  endfunction

  function automatic void eat(logic [7:0] c);
    cst_pkg::kind_e k;
    case (sc_mode)
      cst_pkg::M_IDENT: begin
        if (is_letter(c) || is_num(c)) begin
          if (len_cnt < 16'd6) kw_pre = {kw_pre[39:0], c};
          else kw_pre = '1;
          grow_len();
          step_pos(c);
        end else begin
          put_ident();
          begin_tok(c);
        end
      end
      cst_pkg::M_NUMBER: begin
        if (is_num(c)) begin
          grow_len();
          step_pos(c);
        end else begin
          put_cur(cst_pkg::KInteger, len_cnt, 8'd0, cst_pkg::ErrNone);
          begin_tok(c);
        end
      end
      cst_pkg::M_CHAR_OPEN: begin
        step_pos(c);
        if (c == "\\") begin
          sc_mode = cst_pkg::M_CHAR_ESC;
        end else begin
          dec_ch = c;
          sc_mode = cst_pkg::M_CHAR_CLOSE;
        end
      end
      cst_pkg::M_CHAR_ESC: begin
        if (c inside {"n", "t", "r", "0", "\\", "'", "\""}) begin
          case (c)
            "n": dec_ch = 8'h0a;
            "t": dec_ch = 8'h09;
            "r": dec_ch = 8'h0d;
            "0": dec_ch = 8'h00;
            default: dec_ch = c;
          endcase
          sc_mode = cst_pkg::M_CHAR_CLOSE;
          step_pos(c);
        end else begin
          put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrEscape);
          begin_tok(c);
        end
      end
      cst_pkg::M_CHAR_CLOSE: begin
        if (c == "'") begin
          step_pos(c);
          put_cur(cst_pkg::KCharacter, 16'd1, dec_ch, cst_pkg::ErrNone);
          sc_mode = cst_pkg::M_IDLE;
        end else begin
          put_cur(cst_pkg::KError, 16'd0, 8'd0, cst_pkg::ErrOpenChar);
          begin_tok(c);
        end
      end
      cst_pkg::M_STRING: begin
        step_pos(c);
        if (c == "\"") begin
          put_cur(cst_pkg::KString, len_cnt, 8'd0, cst_pkg::ErrNone);
          sc_mode = cst_pkg::M_IDLE;
        end else begin
          grow_len();
          if (c == "\\") sc_mode = cst_pkg::M_STRING_ESC;
        end
      end
      cst_pkg::M_STRING_ESC: begin
        step_pos(c);
        grow_len();
        sc_mode = cst_pkg::M_STRING;
      end
      cst_pkg::M_OPERATOR: begin
        k = op2(pend_op, c);
        if (k != cst_pkg::KEof) begin
          step_pos(c);
          put_cur(k, 16'd2, 8'd0, cst_pkg::ErrNone);
          sc_mode = cst_pkg::M_IDLE;
        end else if (pend_op == "/" && (c == "/" || c == "*")) begin
          step_pos(c);
          sc_mode = (c == "/") ? cst_pkg::M_LINE_COMMENT : cst_pkg::M_BLOCK;
        end else begin
          put_cur(op1(pend_op), 16'd1, 8'd0, cst_pkg::ErrNone);
          begin_tok(c);
        end
      end
      cst_pkg::M_LINE_COMMENT: begin
        step_pos(c);
        if (c == 8'h0a) sc_mode = cst_pkg::M_IDLE;
      end
      cst_pkg::M_BLOCK: begin
        step_pos(c);
        if (c == "*") sc_mode = cst_pkg::M_BLOCK_STAR;
      end
      cst_pkg::M_BLOCK_STAR: begin
        step_pos(c);
        if (c == "/") sc_mode = cst_pkg::M_IDLE;
        else if (c != "*") sc_mode = cst_pkg::M_BLOCK;
      end
      default: begin_tok(c);
    endcase
  endfunction

  function automatic void lex_byte(cst_pkg::in_t it);
    step_toks.delete();
    if (eof_seen) return;
    if (it.end_of_input || it.next_byte == 8'd0) close_input();
    else eat(it.next_byte);
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  task automatic send(logic [7:0] b, logic e);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 99) < 31) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        data_i <= '{next_byte: b, end_of_input: e};
        @(posedge clk_i);
        if (!full) begin
          lex_byte('{next_byte: b, end_of_input: e});
          n_sent++;
          done = 1;
        end
      end
    end
  endtask

  always @(negedge clk_i) pop <= (!quiet && $urandom_range(0, 99) < 31) ? 1'b0 : 1'b1;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d", data_o.token_kind));
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 16'(data_o.token_kind), 16'(want.token_kind));
        check_field("line_no", data_o.line_no, want.line_no);
        check_field("start_column", data_o.start_column, want.start_column);
        check_field("text_length", data_o.text_length, want.text_length);
        check_field("literal_char", 16'(data_o.literal_char), 16'(want.literal_char));
        check_field("error_code", 16'(data_o.error_code), 16'(want.error_code));
        check_field("last_of_run", 16'(data_o.last_of_run), 16'(want.last_of_run));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [7:0] frag[$];
    int r, n;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    data_i = '0;
    quiet = 1'b0;
    errors = 0;
    n_sent = 0;
    sc_mode = cst_pkg::M_IDLE;
    ln = 16'd1;
    col = 16'd1;
    tok_ln = 16'd1;
    tok_col = 16'd1;
    len_cnt = 16'd0;
    kw_pre = '0;
    pend_op = 8'd0;
    dec_ch = 8'd0;
    eof_seen = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send(dir_rows[i].b, dir_rows[i].e);
      if (dir_rows[i].chk && (step_toks.size() == 0 || step_toks[0].token_kind != dir_rows[i].k
          || step_toks[0].error_code != dir_rows[i].er))
        report_mismatch($sformatf("directed row %0d gives the wrong token", i));
    end
    @(negedge clk_i) push <= 1'b0;
    wait (token_q.size() == 0);

    while (n_sent < 715) begin
      quiet = (n_sent >= 330 && n_sent < 480);
      frag.delete();
      r = $urandom_range(0, 10);
      case (r)
        0: begin
          n = $urandom_range(0, 7);
          for (int j = 0; j < kw_names[n].len(); j++) frag.push_back(kw_names[n][j]);
        end
        1: begin
          frag.push_back(ops[$urandom_range(0, 23)] | 8'h00);
          frag[0] = "_";
          if ($urandom_range(0, 1)) frag[0] = 8'(($urandom_range(0, 1) ? "a" : "A")
                                             + $urandom_range(0, 25));
          repeat ($urandom_range(0, 8))
            case ($urandom_range(0, 2))
              0: frag.push_back(8'("a" + $urandom_range(0, 25)));
              1: frag.push_back(8'("Z" - $urandom_range(0, 25)));
              default: frag.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
        end
        2: repeat ($urandom_range(1, 5)) frag.push_back(8'("0" + $urandom_range(0, 9)));
        3: begin
          frag.push_back("'");
          case ($urandom_range(0, 2))
            0: frag.push_back(8'($urandom_range(1, 255)));
            1: begin
              frag.push_back("\\");
              frag.push_back(esc_set[$urandom_range(0, 6)]);
            end
            default: begin
              frag.push_back("\\");
              frag.push_back(8'($urandom_range(1, 255)));
            end
          endcase
          if ($urandom_range(0, 99) < 85) frag.push_back("'");
        end
        4: begin
          frag.push_back("\"");
          repeat ($urandom_range(0, 8))
            if ($urandom_range(0, 4) == 0) begin
              frag.push_back("\\");
              frag.push_back(8'($urandom_range(1, 255)));
            end else begin
              frag.push_back(8'($urandom_range(32, 126)));
            end
          if ($urandom_range(0, 99) < 90) frag.push_back("\"");
        end
        5: begin
          frag.push_back(ops[$urandom_range(0, 23)]);
          if ($urandom_range(0, 1)) frag.push_back(ops[$urandom_range(0, 8)]);
        end
        6: repeat ($urandom_range(1, 3)) frag.push_back(ws_set[$urandom_range(0, 5)]);
        7: begin
          frag.push_back("/");
          frag.push_back("/");
          repeat ($urandom_range(0, 6)) frag.push_back(8'($urandom_range(11, 255)));
          frag.push_back(8'h0a);
        end
        8: begin
          frag.push_back("/");
          frag.push_back("*");
          repeat ($urandom_range(0, 6)) frag.push_back(cmt[$urandom_range(0, 5)]);
          if ($urandom_range(0, 99) < 90) begin
            frag.push_back("*");
            frag.push_back("/");
          end
        end
        default: frag.push_back(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 1)) frag.push_back(ws_set[$urandom_range(0, 5)]);
      foreach (frag[j]) send(frag[j], 1'b0);
    end
    quiet = 1'b0;

    send("x", 1'b0);
    send(8'($urandom_range(0, 255)), 1'b1);
    send(8'h00, 1'b0);
    send(8'($urandom_range(0, 255)), 1'b1);
    @(negedge clk_i) push <= 1'b0;

    wait (token_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
